### design/ptsu_pkg.sv
// types, constants and stage functions of the particle target steering update
`default_nettype none

package ptsu_pkg;

  localparam logic [2:0] REG_DELAYED_INIT   = 3'd0;
  localparam logic [2:0] REG_IDLE_DISTANCE  = 3'd1;
  localparam logic [2:0] REG_FORCE_FIELD    = 3'd2;
  localparam logic [2:0] REG_VELOCITY_FIELD = 3'd3;
  localparam logic [2:0] REG_FORCE_MAG      = 3'd4;
  localparam logic [2:0] REG_IDLE_TO_ACTIVE = 3'd5;
  localparam logic [2:0] REG_ACTIVE_TO_IDLE = 3'd6;
  localparam logic [2:0] REG_DAMPING        = 3'd7;

  // stage map of the pipeline
  localparam int ST_PRE0 = 0;
  localparam int ST_SUM  = 1;
  localparam int ST_SQ1  = 2;
  localparam int SQ1_LEN = 32;
  localparam int ST_PRE1 = ST_SQ1 + SQ1_LEN;
  localparam int ST_PRE2 = ST_PRE1 + 1;
  localparam int ST_DV1  = ST_PRE2 + 1;
  localparam int DIV_LEN = 17;
  localparam int ST_BL1  = ST_DV1 + DIV_LEN;
  localparam int ST_BL2  = ST_BL1 + 1;
  localparam int ST_BL3  = ST_BL2 + 1;
  localparam int ST_BL4  = ST_BL3 + 1;
  localparam int ST_BL5  = ST_BL4 + 1;
  localparam int ST_SQ2  = ST_BL5 + 1;
  localparam int SQ2_LEN = 17;
  localparam int ST_PRE3 = ST_SQ2 + SQ2_LEN;
  localparam int ST_DV2  = ST_PRE3 + 1;
  localparam int NSTAGE  = ST_DV2 + DIV_LEN;

  typedef struct packed {
    logic [30:0]        delayed_init;
    logic [15:0]        idle_distance;
    logic [15:0]        force_field_distance;
    logic [15:0]        velocity_field_distance;
    logic signed [15:0] force_magnitude;
    logic [30:0]        idle_to_active_time;
    logic [30:0]        active_to_idle_time;
    logic [16:0]        damping;
  } cfg_t;

  typedef struct packed {
    logic [31:0] timer;
    logic [47:0] target;
    logic [47:0] force_v;
    logic [47:0] velocity;
  } out_t;

  typedef struct {
    logic               kind;
    logic [47:0]        pos;
    logic [47:0]        vel;
    logic [47:0]        frc;
    logic [47:0]        tgt;
    logic [30:0]        life;
    logic signed [31:0] timer;
    logic [30:0]        dt;
    logic signed [16:0] d [3];
    logic [32:0]        sqd [3];
    logic [30:0]        sqv [3];
    logic [63:0]        rad [3];
    logic [35:0]        rem [3];
    logic [31:0]        root [3];
    logic [17:0]        distance;
    logic [31:0]        lend;
    logic [31:0]        spd;
    logic               far;
    logic               act;
    logic signed [32:0] pf [3];
    logic signed [33:0] pdmp [3];
    logic [63:0]        drem [10];
    logic [63:0]        dden [10];
    logic [16:0]        dq [10];
    logic               dneg [10];
    logic               dbig [3];
    logic signed [15:0] vid [3];
    logic signed [31:0] tid;
    logic signed [15:0] fnew [3];
    logic signed [17:0] ud [3];
    logic signed [17:0] uv [3];
    logic [16:0]        e;
    logic signed [35:0] pb1 [3];
    logic signed [35:0] pb2 [3];
    logic signed [17:0] b [3];
    logic [32:0]        sqb [3];
    logic signed [48:0] pbs [3];
    logic               blz;
  } item_t;

  function automatic logic signed [15:0] lane(input logic [47:0] v, input int i);
    return $signed(v[16*i +: 16]);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [31:0] a);
    if (a > 32'sd32767) return 16'sh7FFF;
    if (a < -32'sd32768) return 16'sh8000;
    return 16'(a);
  endfunction

  function automatic item_t stage_step(input int s, input item_t xi, input cfg_t c);
    item_t x;
    logic signed [15:0] pl, tl, vl, fl;
    logic signed [33:0] p34;
    logic signed [31:0] p32;
    logic [33:0] sd;
    logic [31:0] sv;
    logic [35:0] rs, trial;
    logic [17:0] den18;
    logic [15:0] ffd, vfd;
    logic [16:0] dmp;
    logic [63:0] mg, sh;
    logic signed [63:0] sx;
    logic [16:0] dm;
    logic [33:0] mg34;
    logic [15:0] q16;
    logic [33:0] lt;
    logic [31:0] lts;
    logic signed [33:0] t34;
    logic signed [18:0] f19;
    logic [16:0] w;
    logic signed [36:0] sm;
    logic [36:0] mg37;
    logic [17:0] b18;
    logic signed [35:0] bb;
    int k;
    x = xi;
    ffd = (c.force_field_distance == 16'd0) ? 16'd1 : c.force_field_distance;
    vfd = (c.velocity_field_distance == 16'd0) ? 16'd1 : c.velocity_field_distance;
    dmp = (c.damping > 17'd65536) ? 17'd65536 : c.damping;
    if (s == ST_PRE0) begin
      // target follows position: at init when no delay, on update while young
      if (x.kind ? (c.delayed_init != 31'd0 && x.life < c.delayed_init)
                 : (c.delayed_init == 31'd0))
        x.tgt = x.pos;
      for (int i = 0; i < 3; i++) begin
        pl = lane(x.pos, i);
        tl = lane(x.tgt, i);
        vl = lane(x.vel, i);
        x.d[i] = 17'(tl) - 17'(pl);
        p34 = x.d[i] * x.d[i];
        x.sqd[i] = p34[32:0];
        p32 = vl * vl;
        x.sqv[i] = p32[30:0];
      end
    end else if (s == ST_SUM) begin
      sd = 34'(x.sqd[0]) + 34'(x.sqd[1]) + 34'(x.sqd[2]);
      sv = 32'(x.sqv[0]) + 32'(x.sqv[1]) + 32'(x.sqv[2]);
      x.rad[0] = {30'd0, sd};
      x.rad[1] = {2'd0, sd, 28'd0};
      x.rad[2] = {4'd0, sv, 28'd0};
      for (int i = 0; i < 3; i++) begin
        x.rem[i] = '0;
        x.root[i] = '0;
      end
    end else if ((s >= ST_SQ1 && s < ST_SQ1 + SQ1_LEN) ||
                 (s >= ST_SQ2 && s < ST_SQ2 + SQ2_LEN)) begin
      // one root bit per stage, two radicand bits consumed
      for (int i = 0; i < 3; i++) begin
        if (s < ST_SQ2 || i == 0) begin
          rs = {x.rem[i][33:0], x.rad[i][63:62]};
          trial = {2'd0, x.root[i], 2'b01};
          if (rs >= trial) begin
            x.rem[i] = rs - trial;
            x.root[i] = {x.root[i][30:0], 1'b1};
          end else begin
            x.rem[i] = rs;
            x.root[i] = {x.root[i][30:0], 1'b0};
          end
          x.rad[i] = {x.rad[i][61:0], 2'b00};
        end
      end
    end else if (s == ST_PRE1) begin
      x.distance = x.root[0][17:0];
      x.lend = x.root[1];
      x.spd = x.root[2];
      x.far = x.distance > 18'(c.idle_distance);
      x.act = x.far && ($signed({1'b0, x.life}) >= x.timer);
      for (int i = 0; i < 3; i++) begin
        x.pf[i] = $signed(c.force_magnitude) * x.d[i];
        x.pdmp[i] = lane(x.vel, i) * $signed({1'b0, dmp});
      end
    end else if (s == ST_PRE2) begin
      den18 = (x.distance > 18'(ffd)) ? x.distance : 18'(ffd);
      for (int i = 0; i < 3; i++) begin
        sx = 64'(x.pf[i]);
        mg = (sx < 0) ? 64'(-sx) : 64'(sx);
        x.drem[i] = mg;
        x.dden[i] = 64'(den18);
        x.dneg[i] = x.pf[i] < 0;
        x.dbig[i] = mg >= (64'(den18) << 17);
        dm = (x.d[i] < 0) ? 17'(-x.d[i]) : 17'(x.d[i]);
        x.drem[3+i] = 64'(dm) << 30;
        x.dden[3+i] = 64'(x.lend);
        x.dneg[3+i] = x.d[i] < 0;
        vl = lane(x.vel, i);
        dm = (vl < 0) ? 17'(-17'(vl)) : 17'(vl);
        x.drem[6+i] = 64'(dm) << 30;
        x.dden[6+i] = 64'(x.spd);
        x.dneg[6+i] = vl < 0;
        mg34 = (x.pdmp[i] < 0) ? 34'(-x.pdmp[i]) : 34'(x.pdmp[i]);
        q16 = mg34[31:16];
        x.vid[i] = (x.timer < 0) ? ((x.pdmp[i] < 0) ? -$signed(q16) : $signed(q16)) : vl;
      end
      x.drem[9] = 64'(x.distance) << 16;
      x.dden[9] = 64'(vfd);
      x.dneg[9] = 1'b0;
      for (int j = 0; j < 10; j++) x.dq[j] = '0;
      // idle and settling timer
      lt = {3'd0, x.life} + {3'd0, c.idle_to_active_time};
      lts = (lt > 34'h7FFFFFFF) ? 32'h7FFFFFFF : lt[31:0];
      t34 = 34'(x.timer) + $signed({3'd0, x.dt});
      if (x.timer < 0) begin
        x.tid = (t34 > 0) ? $signed(lts) : t34[31:0];
      end else if ($signed({1'b0, x.life}) >= x.timer) begin
        x.tid = 32'd0 - {1'b0, c.active_to_idle_time};
      end else begin
        x.tid = ($signed(lts) > x.timer) ? $signed(lts) : x.timer;
      end
    end else if ((s >= ST_DV1 && s < ST_DV1 + DIV_LEN) ||
                 (s >= ST_DV2 && s < ST_DV2 + DIV_LEN)) begin
      // one quotient bit per stage, msb first
      k = (s < ST_DV2) ? (ST_DV1 + DIV_LEN - 1 - s) : (ST_DV2 + DIV_LEN - 1 - s);
      for (int j = 0; j < 10; j++) begin
        if (s < ST_DV2 || j < 3) begin
          sh = x.dden[j] << k;
          if (x.drem[j] >= sh) begin
            x.drem[j] = x.drem[j] - sh;
            x.dq[j][k] = 1'b1;
          end
        end
      end
    end else if (s == ST_BL1) begin
      for (int i = 0; i < 3; i++) begin
        fl = lane(x.frc, i);
        f19 = 19'(fl) + (x.dneg[i] ? -$signed({2'd0, x.dq[i]}) : $signed({2'd0, x.dq[i]}));
        if (x.dbig[i]) x.fnew[i] = x.dneg[i] ? 16'sh8000 : 16'sh7FFF;
        else x.fnew[i] = sat16(32'(f19));
        x.ud[i] = x.dneg[3+i] ? -$signed({1'b0, x.dq[3+i]}) : $signed({1'b0, x.dq[3+i]});
        if (x.spd == 32'd0) x.uv[i] = '0;
        else x.uv[i] = x.dneg[6+i] ? -$signed({1'b0, x.dq[6+i]})
                                   : $signed({1'b0, x.dq[6+i]});
      end
      x.e = (x.distance >= 18'(vfd)) ? 17'd65536 : x.dq[9];
    end else if (s == ST_BL2) begin
      w = 17'd65536 - x.e;
      for (int i = 0; i < 3; i++) begin
        x.pb1[i] = x.ud[i] * $signed({1'b0, w});
        x.pb2[i] = x.uv[i] * $signed({1'b0, x.e});
      end
    end else if (s == ST_BL3) begin
      for (int i = 0; i < 3; i++) begin
        sm = 37'(x.pb1[i]) + 37'(x.pb2[i]);
        mg37 = (sm < 0) ? 37'(-sm) : 37'(sm);
        b18 = 18'(mg37 >> 16);
        x.b[i] = (sm < 0) ? -$signed(b18) : $signed(b18);
      end
    end else if (s == ST_BL4) begin
      for (int i = 0; i < 3; i++) begin
        bb = x.b[i] * x.b[i];
        x.sqb[i] = bb[32:0];
        x.pbs[i] = x.b[i] * $signed({1'b0, x.spd[29:0]});
      end
    end else if (s == ST_BL5) begin
      sd = 34'(x.sqb[0]) + 34'(x.sqb[1]) + 34'(x.sqb[2]);
      x.rad[0] = {sd, 30'd0};
      x.rem[0] = '0;
      x.root[0] = '0;
    end else if (s == ST_PRE3) begin
      x.blz = x.root[0][16:0] == 17'd0;
      for (int i = 0; i < 3; i++) begin
        sx = 64'(x.pbs[i]);
        mg = (sx < 0) ? 64'(-sx) : 64'(sx);
        x.drem[i] = mg;
        x.dden[i] = 64'(x.root[0][16:0]) << 14;
        x.dq[i] = '0;
        x.dneg[i] = x.pbs[i] < 0;
        x.dbig[i] = mg >= ((64'(x.root[0][16:0]) << 14) << 17);
      end
    end
    return x;
  endfunction

  function automatic out_t out_select(input item_t x, input cfg_t c);
    out_t o;
    logic signed [15:0] vn;
    o.target = x.tgt;
    o.velocity = x.vel;
    o.force_v = x.frc;
    o.timer = x.timer;
    if (!x.kind) begin
      o.timer = {1'b0, c.idle_to_active_time};
    end else if (x.far) begin
      if (x.act) begin
        for (int i = 0; i < 3; i++) begin
          if (x.blz) vn = '0;
          else if (x.dbig[i]) vn = x.dneg[i] ? 16'sh8000 : 16'sh7FFF;
          else vn = sat16(x.dneg[i] ? -$signed({15'd0, x.dq[i]}) : $signed({15'd0, x.dq[i]}));
          o.velocity[16*i +: 16] = vn;
          o.force_v[16*i +: 16] = x.fnew[i];
        end
      end
    end else begin
      for (int i = 0; i < 3; i++) o.velocity[16*i +: 16] = x.vid[i];
      o.timer = x.tid;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

### design/particle_target_steering_update.sv
// top level of the particle target steering update pipeline
`default_nettype none

// channel   dir  signals                        request
// s_        in   tvalid tready tdata tuser      one particle (kind in tuser)
// m_        out  tvalid tready tdata            one updated particle
// cfg_      in   we index data                  one register write
// one particle accepted per cycle unless the pipeline holds (see below); the pipeline depth is
// set by the two bit-per-stage square root pipes and the two divider pipes
// rst clears the registers to their defaults, the stage valid bits and the buffer
// a two-entry output buffer keeps input open while a result waits; the whole
// pipeline holds only when the buffer is full and m_tready is low

module particle_target_steering_update (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // position, velocity_in, force_in, target_in, life, timer_in, delta_time, pad
  input  wire logic [287:0] s_tdata,
  // kind
  input  wire logic [0:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // velocity_out, force_out, target_out, timer_out
  output logic [175:0]      m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [30:0]  cfg_data
);

  localparam int N = ptsu_pkg::NSTAGE;

  ptsu_pkg::cfg_t  cfg;
  ptsu_pkg::item_t in_item;
  ptsu_pkg::item_t st [N];
  logic [N-1:0]    vld;
  ptsu_pkg::out_t  res, ob0, ob1;
  logic [1:0]      cnt;
  logic            en, push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delayed_init <= 31'd0;
      cfg.idle_distance <= 16'd26;
      cfg.force_field_distance <= 16'd384;
      cfg.velocity_field_distance <= 16'd128;
      cfg.force_magnitude <= 16'sd256;
      cfg.idle_to_active_time <= 31'd131072;
      cfg.active_to_idle_time <= 31'd13107;
      cfg.damping <= 17'd52429;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptsu_pkg::REG_DELAYED_INIT:   cfg.delayed_init <= cfg_data;
        ptsu_pkg::REG_IDLE_DISTANCE:  cfg.idle_distance <= cfg_data[15:0];
        ptsu_pkg::REG_FORCE_FIELD:    cfg.force_field_distance <= cfg_data[15:0];
        ptsu_pkg::REG_VELOCITY_FIELD: cfg.velocity_field_distance <= cfg_data[15:0];
        ptsu_pkg::REG_FORCE_MAG:      cfg.force_magnitude <= $signed(cfg_data[15:0]);
        ptsu_pkg::REG_IDLE_TO_ACTIVE: cfg.idle_to_active_time <= cfg_data;
        ptsu_pkg::REG_ACTIVE_TO_IDLE: cfg.active_to_idle_time <= cfg_data;
        ptsu_pkg::REG_DAMPING:        cfg.damping <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item = '{default: '0};
    in_item.kind = s_tuser[0];
    in_item.pos = s_tdata[47:0];
    in_item.vel = s_tdata[95:48];
    in_item.frc = s_tdata[143:96];
    in_item.tgt = s_tdata[191:144];
    in_item.life = s_tdata[222:192];
    in_item.timer = $signed(s_tdata[254:223]);
    in_item.dt = s_tdata[285:255];
  end

  assign en = (cnt != 2'd2) || m_tready;
  assign s_tready = en;

  for (genvar j = 0; j < N; j++) begin : g_stage
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) st[j] <= ptsu_pkg::stage_step(j, in_item, cfg);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) st[j] <= ptsu_pkg::stage_step(j, st[j-1], cfg);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], s_tvalid};
    end
  end

  assign res = ptsu_pkg::out_select(st[N-1], cfg);
  assign push = en && vld[N-1];
  assign pop = m_tvalid && m_tready;
  assign m_tvalid = cnt != 2'd0;
  assign m_tdata = ob0;

  // two-entry output buffer, head in ob0
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && push) begin
      if (cnt == 2'd1) ob0 <= res;
      else begin
        ob0 <= ob1;
        ob1 <= res;
      end
    end else if (pop) begin
      ob0 <= ob1;
    end else if (push) begin
      if (cnt == 2'd0) ob0 <= res;
      else ob1 <= res;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !m_tready) |-> !s_tready)
    else $error("input open while output buffer full");
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted request did not enter the pipeline");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && push) |-> pop)
    else $error("push into full output buffer");

endmodule

`default_nettype wire

### tb/particle_target_steering_update_tb.sv
// testbench of the particle target steering update: directed and random particles against a predictor
`timescale 1ns / 100ps

module particle_target_steering_update_tb;

  typedef struct {
    bit          kind;
    bit [47:0]   pos, vel, frc, tgt;
    bit [30:0]   life;
    bit [31:0]   timer;
    bit [30:0]   dt;
  } particle_t;

  class steering_scoreboard;
    longint unsigned regs [8];
    bit [175:0] expected_q [$];
    int errors;

    function new();
      regs[ptsu_pkg::REG_DELAYED_INIT] = 0;
      regs[ptsu_pkg::REG_IDLE_DISTANCE] = 26;
      regs[ptsu_pkg::REG_FORCE_FIELD] = 384;
      regs[ptsu_pkg::REG_VELOCITY_FIELD] = 128;
      regs[ptsu_pkg::REG_FORCE_MAG] = 256;
      regs[ptsu_pkg::REG_IDLE_TO_ACTIVE] = 131072;
      regs[ptsu_pkg::REG_ACTIVE_TO_IDLE] = 13107;
      regs[ptsu_pkg::REG_DAMPING] = 52429;
      errors = 0;
    endfunction

    function void set_reg(int idx, longint unsigned val);
      case (idx)
        ptsu_pkg::REG_IDLE_DISTANCE, ptsu_pkg::REG_FORCE_FIELD,
        ptsu_pkg::REG_VELOCITY_FIELD, ptsu_pkg::REG_FORCE_MAG:
          regs[idx] = val & 16'hFFFF;
        ptsu_pkg::REG_DAMPING: regs[idx] = val & 17'h1FFFF;
        default: regs[idx] = val & 31'h7FFFFFFF;
      endcase
    endfunction

    function longint lane_of(bit [47:0] v, int i);
      return longint'($signed(v[16*i +: 16]));
    endfunction

    function longint sat16(longint x);
      return (x > 32767) ? 32767 : (x < -32768) ? -32768 : x;
    endfunction

    function longint sat32(longint x);
      return (x > 64'sd2147483647) ? 64'sd2147483647 :
             (x < -64'sd2147483648) ? -64'sd2147483648 : x;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned sq_sum(longint l [3]);
      return longint'(l[0]*l[0] + l[1]*l[1] + l[2]*l[2]);
    endfunction

    function bit [47:0] pack_lanes(longint l [3]);
      bit [47:0] r;
      for (int i = 0; i < 3; i++) r[16*i +: 16] = 16'(sat16(l[i]));
      return r;
    endfunction

    // predicted result of one particle under the current register set
    function bit [175:0] steer(particle_t p);
      longint ffd, vfd, damp, fm, life, timer, dt, distance, den, e, blen, spd, ld, lv, t2;
      longint v [3], f [3], d [3], ud [3], uv [3], b [3];
      bit [47:0] tgt;
      ffd = regs[ptsu_pkg::REG_FORCE_FIELD] ? regs[ptsu_pkg::REG_FORCE_FIELD] : 1;
      vfd = regs[ptsu_pkg::REG_VELOCITY_FIELD] ? regs[ptsu_pkg::REG_VELOCITY_FIELD] : 1;
      damp = (regs[ptsu_pkg::REG_DAMPING] > 65536) ? 65536 : regs[ptsu_pkg::REG_DAMPING];
      fm = longint'($signed(16'(regs[ptsu_pkg::REG_FORCE_MAG])));
      life = p.life;
      timer = longint'($signed(p.timer));
      dt = p.dt;
      tgt = p.tgt;
      if (!p.kind) begin
        if (regs[ptsu_pkg::REG_DELAYED_INIT] == 0) tgt = p.pos;
        return {32'(regs[ptsu_pkg::REG_IDLE_TO_ACTIVE]), tgt, p.frc, p.vel};
      end
      if (regs[ptsu_pkg::REG_DELAYED_INIT] > 0 && life < regs[ptsu_pkg::REG_DELAYED_INIT])
        tgt = p.pos;
      for (int i = 0; i < 3; i++) begin
        v[i] = lane_of(p.vel, i);
        f[i] = lane_of(p.frc, i);
        d[i] = lane_of(tgt, i) - lane_of(p.pos, i);
      end
      distance = floor_sqrt(sq_sum(d));
      if (distance > longint'(regs[ptsu_pkg::REG_IDLE_DISTANCE])) begin
        if (life >= timer && distance > 0) begin
          den = (distance > ffd) ? distance : ffd;
          for (int i = 0; i < 3; i++) f[i] = sat16(f[i] + (fm * d[i]) / den);
          e = (distance >= vfd) ? 65536 : (distance * 65536) / vfd;
          ld = floor_sqrt(sq_sum(d) << 28);
          lv = floor_sqrt(sq_sum(v) << 28);
          for (int i = 0; i < 3; i++) begin
            ud[i] = ld ? (d[i] * 64'sd1073741824) / ld : 0;
            uv[i] = lv ? (v[i] * 64'sd1073741824) / lv : 0;
            b[i] = (ud[i] * (65536 - e) + uv[i] * e) / 65536;
          end
          blen = floor_sqrt(sq_sum(b));
          spd = lv;
          for (int i = 0; i < 3; i++) v[i] = blen ? sat16((b[i] * spd) / (blen * 16384)) : 0;
        end
      end else if (timer < 0) begin
        timer += dt;
        for (int i = 0; i < 3; i++) v[i] = (v[i] * damp) / 65536;
        if (timer > 0) timer = sat32(life + longint'(regs[ptsu_pkg::REG_IDLE_TO_ACTIVE]));
      end else if (life >= timer) begin
        timer = -longint'(regs[ptsu_pkg::REG_ACTIVE_TO_IDLE]);
      end else begin
        t2 = sat32(life + longint'(regs[ptsu_pkg::REG_IDLE_TO_ACTIVE]));
        if (t2 > timer) timer = t2;
      end
      return {32'(sat32(timer)), tgt, pack_lanes(f), pack_lanes(v)};
    endfunction

    function void note_particle(particle_t p);
      expected_q.push_back(steer(p));
    endfunction

    function void check_result(bit [175:0] got);
      bit [175:0] exp_r;
      if (expected_q.size() == 0) begin
        $error("result %h with no particle pending", got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got[47:0] != exp_r[47:0]) begin
        $error("velocity_out expected %h got %h", exp_r[47:0], got[47:0]); errors++;
      end
      if (got[95:48] != exp_r[95:48]) begin
        $error("force_out expected %h got %h", exp_r[95:48], got[95:48]); errors++;
      end
      if (got[143:96] != exp_r[143:96]) begin
        $error("target_out expected %h got %h", exp_r[143:96], got[143:96]); errors++;
      end
      if (got[175:144] != exp_r[175:144]) begin
        $error("timer_out expected %h got %h", exp_r[175:144], got[175:144]); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [287:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [175:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = ptsu_pkg::REG_DELAYED_INIT;
  logic [30:0] cfg_data = '0;

  steering_scoreboard sb = new();
  int idle_cycles = 0;
  bit rx_hold = 1'b0;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 150;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  particle_target_steering_update DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      particle_t p;
      p.kind = s_tuser[0];
      p.pos = s_tdata[47:0];     p.vel = s_tdata[95:48];
      p.frc = s_tdata[143:96];   p.tgt = s_tdata[191:144];
      p.life = s_tdata[222:192]; p.timer = s_tdata[254:223];
      p.dt = s_tdata[285:255];
      sb.note_particle(p);
    end
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stalls: mostly short, a few long, with stall-free stretches
  initial begin
    int len;
    forever begin
      len = $urandom_range(1, 60);
      repeat (len) @(posedge clk) m_tready <= 1'b1;
      if (!rx_hold) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 4);
        repeat (len) @(posedge clk) m_tready <= 1'b0;
      end
    end
  end

  function automatic bit [47:0] rand_vec();
    bit [47:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1, 2: for (int i = 0; i < 3; i++)
              v[16*i +: 16] = 16'($signed($urandom_range(0, 1600)) - 800);
      default: v = {16'($urandom), 32'($urandom)};
    endcase
    return v;
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    p.kind = ($urandom_range(0, 7) != 0);
    p.pos = rand_vec();
    p.vel = rand_vec();
    p.frc = rand_vec();
    p.tgt = rand_vec();
    // targets close to the position exercise the arrival and settling paths
    if ($urandom_range(0, 2) == 0)
      for (int i = 0; i < 3; i++)
        p.tgt[16*i +: 16] = p.pos[16*i +: 16] + 16'($signed($urandom_range(0, 40)) - 20);
    p.life = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 400000));
    case ($urandom_range(0, 4))
      0: p.timer = -32'($urandom_range(0, 200000));
      1: p.timer = 32'(p.life) + 32'($signed($urandom_range(0, 4000)) - 2000);
      2: p.timer = 32'($urandom_range(0, 400000));
      default: p.timer = $urandom;
    endcase
    p.dt = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 70000));
    return p;
  endfunction

  task automatic send_particle(particle_t p);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= p.kind;
    s_tdata <= {2'b00, p.dt, p.timer, p.life, p.tgt, p.frc, p.vel, p.pos};
    do @(posedge clk); while (!s_tready);
    gap = 0;
    case ($urandom_range(0, 9))
      0, 1: gap = $urandom_range(1, 3);
      2: gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : 0;
      default: gap = 0;
    endcase
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(longint unsigned vals [8]);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= 31'(vals[i]);
      sb.set_reg(i, vals[i]);
    end
    @(posedge clk) cfg_we <= 1'b0;
  endtask

  initial begin
    particle_t p;
    longint unsigned vals [8];
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes under the reset register set
    for (int k = 0; k < 16; k++) begin
      p = rand_particle();
      p.kind = (k != 0 && k != 8);
      case (k % 8)
        0: begin p.pos = '1; p.tgt = '0; end
        1: begin p.pos = {3{16'h8000}}; p.tgt = {3{16'h7FFF}}; p.life = '1; p.timer = '0; end
        2: begin p.vel = '0; p.tgt = {16'h0, 16'h0, 16'h0400}; p.pos = '0;
                 p.life = 31'd5; p.timer = 32'd0; end
        3: begin p.tgt = p.pos; p.timer = 32'h8000_0000; p.dt = '1; end
        4: begin p.tgt = p.pos; p.timer = 32'h7FFF_FFFF; p.life = '1; end
        5: begin p.tgt = p.pos; p.timer = 32'd100; p.life = 31'd100; end
        6: begin p.tgt = p.pos; p.timer = -32'sd10; p.dt = 31'd5; end
        7: begin p.frc = {3{16'h7FFF}}; p.vel = {3{16'h8000}}; p.pos = '0;
                 p.tgt = {16'h0200, 16'h0, 16'h0}; p.life = 31'd1000; p.timer = 32'd0; end
      endcase
      send_particle(p);
    end
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < 8; i++) begin
        case (phase)
          0: vals[i] = 0;
          1: vals[i] = (i == ptsu_pkg::REG_FORCE_MAG) ? 64'h7FFF :
                       (i == ptsu_pkg::REG_DAMPING) ? 64'h1FFFF :
                       (i == ptsu_pkg::REG_FORCE_FIELD || i == ptsu_pkg::REG_VELOCITY_FIELD ||
                        i == ptsu_pkg::REG_IDLE_DISTANCE) ? 64'hFFFF : 64'h7FFFFFFF;
          2: vals[i] = (i == ptsu_pkg::REG_FORCE_MAG) ? 64'h8000 :
                       (i == ptsu_pkg::REG_DAMPING) ? 65536 :
                       (i == ptsu_pkg::REG_IDLE_DISTANCE) ? 0 : 1;
          default: vals[i] = (i == ptsu_pkg::REG_DELAYED_INIT) ?
                         $urandom_range(0, 1) * $urandom_range(0, 300000) :
                       (i == ptsu_pkg::REG_IDLE_DISTANCE) ? $urandom_range(0, 60) :
                       (i == ptsu_pkg::REG_FORCE_FIELD || i == ptsu_pkg::REG_VELOCITY_FIELD) ?
                         $urandom_range(1, 1000) :
                       (i == ptsu_pkg::REG_FORCE_MAG) ? 64'($urandom_range(0, 65535)) :
                       (i == ptsu_pkg::REG_DAMPING) ? $urandom_range(0, 65536) :
                         $urandom_range(0, 300000);
        endcase
      end
      write_regs(vals);
      for (int n = 0; n < 310; n++) begin
        send_particle(rand_particle());
        // hold off once per phase until every result is out
        if (n == 150) begin
          rx_hold = (phase == 3);
          drain();
          rx_hold = 1'b0;
        end
      end
      drain();
    end

    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
